[rtl/core/tnlj_pkg.sv]
// shared types, codes and constants for the theta nested loop join
package tnlj_pkg;

   localparam int LEFT_ROWS_DEFAULT = 32;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int IN_KEY_WIDTH      = 32;
   localparam int ROW_WIDTH         = 6;
   localparam int RIGHT_ROW_WIDTH   = 16;
   localparam int CSR_DATA_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH   = 1;

   localparam logic [1:0] OPER_LOAD   = 2'd0;
   localparam logic [1:0] OPER_PROBE  = 2'd1;
   localparam logic [1:0] OPER_FINISH = 2'd2;

   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_LE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;
   localparam logic [2:0] CMP_GE = 3'd5;

   localparam int MODE_LEFT_BIT  = 0;
   localparam int MODE_RIGHT_BIT = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_OP = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTER_MODE = 1'd1;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [IN_KEY_WIDTH-1:0] key;
      logic [RIGHT_ROW_WIDTH-1:0] right_row;
   } req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]       left_row;
      logic [RIGHT_ROW_WIDTH-1:0] right_row_out;
      logic                       left_null;
      logic                       right_null;
      logic                       last;
      logic                       overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic probe;
      logic scan;
      logic outer_left;
      logic pop;
      logic clear;
   } cell_cmd_type;

endpackage

[rtl/core/tnlj_cell.sv]
// one left row: stored key, fill and match flags, compare and result claim chain
module tnlj_cell
   import tnlj_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [2:0]           compare_op,
   input  logic [KEY_WIDTH-1:0] load_key,
   input  logic [KEY_WIDTH-1:0] probe_key,
   input  logic                 prev_valid,
   input  logic                 claim_in,
   output logic                 valid,
   output logic                 pending,
   output logic                 sel,
   output logic                 claim_out
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 valid_ff, valid_in;
   logic                 matched_ff, matched_in;
   logic                 pending_ff, pending_in;
   logic                 load_here;
   logic                 hit;

   assign load_here = cmd.load && prev_valid && !valid_ff;
   assign sel       = pending_ff && !claim_in;
   assign claim_out = claim_in || pending_ff;
   assign valid     = valid_ff;
   assign pending   = pending_ff;

   always_comb begin
      case (compare_op)
         CMP_EQ:  hit = key_ff == probe_key;
         CMP_NE:  hit = key_ff != probe_key;
         CMP_LT:  hit = $signed(key_ff) <  $signed(probe_key);
         CMP_LE:  hit = $signed(key_ff) <= $signed(probe_key);
         CMP_GT:  hit = $signed(key_ff) >  $signed(probe_key);
         CMP_GE:  hit = $signed(key_ff) >= $signed(probe_key);
         default: hit = 1'b0;
      endcase
   end

   always_comb begin
      key_in     = load_here ? load_key : key_ff;
      valid_in   = valid_ff;
      matched_in = matched_ff;
      pending_in = pending_ff;
      if (cmd.clear) begin
         valid_in   = 1'b0;
         matched_in = 1'b0;
         pending_in = 1'b0;
      end else begin
         if (load_here) begin
            valid_in   = 1'b1;
            matched_in = 1'b0;
         end
         if (cmd.probe) begin
            pending_in = valid_ff && hit;
            if (valid_ff && hit) begin
               matched_in = 1'b1;
            end
         end else if (cmd.scan) begin
            pending_in = valid_ff && !matched_ff && cmd.outer_left;
         end else if (cmd.pop && sel) begin
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         matched_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         matched_ff <= matched_in;
         pending_ff <= pending_in;
      end
   end

endmodule

[rtl/core/theta_nested_loop_join.sv]
// top level: request capture, control sequencer, chain of left-row cells, result register
//
// usage
//   req channel: one request per handshake (valid high, stall low). operation
//   load stores a left key in the next free cell (row numbers in load order),
//   probe compares its key against every stored key, finish reports unmatched
//   left rows when left outer mode is set and empties the store.
//   rsp channel: row pairs, one per handshake, last set on the final result of
//   a request. csr port: write compare_op (index 0) and outer_mode (index 1)
//   while the block is idle.
//   sequence: a load is stored in the next free cell; when the store is full
//   no key is stored and a status result with overflow set goes out instead.
//   a probe or finish runs its setup (capture, parallel compare in all cells)
//   and then its results; the result register and the claim chain through
//   the cells hand out one matching row per cycle unless the result side stalls.
//   the block holds one request at a time; req_stall is high until it is done.
//   a stalled result holds in the result register and the sequencer waits.
//   reset empties the store, clears the match flags and the overflow flag and
//   sets both csr registers to zero; no clearing pass is needed.
module theta_nested_loop_join
   import tnlj_pkg::*;
#(
   parameter int LEFT_ROWS = LEFT_ROWS_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int IDX_WIDTH = $clog2(LEFT_ROWS);

   typedef enum logic [2:0] {
      IDLE,
      PROBE_CMP,
      FIN_CMP,
      EMIT_PROBE,
      EMIT_FIN,
      EMIT_STATUS
   } state_type;

   state_type                  state_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;
   logic                       dropped_ff;
   logic                       emitted_ff;
   logic [KEY_WIDTH-1:0]       cur_key_ff;
   logic [RIGHT_ROW_WIDTH-1:0] cur_row_ff;
   logic [2:0]                 compare_op_ff;
   logic [1:0]                 outer_mode_ff;

   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 store_full;
   logic                 pending_any;
   logic                 remaining_any;
   logic [KEY_WIDTH-1:0] req_key_ext;
   logic [IDX_WIDTH-1:0] sel_index;
   cell_cmd_type         cmd;

   logic [LEFT_ROWS-1:0] valid_vec;
   logic [LEFT_ROWS-1:0] pending_vec;
   logic [LEFT_ROWS-1:0] sel_vec;
   logic [LEFT_ROWS:0]   claim_chain;

   assign req_stall   = state_ff != IDLE;
   assign accept      = req_valid && (state_ff == IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign req_key_ext = KEY_WIDTH'($unsigned(req_payload.key));
   assign store_full  = valid_vec[LEFT_ROWS-1];

   assign claim_chain[0] = 1'b0;
   assign pending_any    = claim_chain[LEFT_ROWS];
   assign remaining_any  = |(pending_vec & ~sel_vec);

   assign rsp_load = out_free
                     && (((state_ff == EMIT_PROBE)
                          && (pending_any || (outer_mode_ff[MODE_RIGHT_BIT] && !emitted_ff)))
                         || ((state_ff == EMIT_FIN) && pending_any)
                         || (state_ff == EMIT_STATUS));

   always_comb begin
      sel_index = '0;
      for (int i = 0; i < LEFT_ROWS; i++) begin
         if (sel_vec[i]) begin
            sel_index = sel_index | IDX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      cmd.load       = accept && (req_payload.operation == OPER_LOAD);
      cmd.probe      = state_ff == PROBE_CMP;
      cmd.scan       = state_ff == FIN_CMP;
      cmd.outer_left = outer_mode_ff[MODE_LEFT_BIT];
      cmd.pop        = ((state_ff == EMIT_PROBE) || (state_ff == EMIT_FIN))
                       && out_free && pending_any;
      cmd.clear      = (state_ff == EMIT_FIN)
                       && (!pending_any || (out_free && !remaining_any));
   end

   for (genvar g = 0; g < LEFT_ROWS; g++) begin : g_cell
      tnlj_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .compare_op (compare_op_ff),
         .load_key   (req_key_ext),
         .probe_key  (cur_key_ff),
         .prev_valid ((g == 0) ? 1'b1 : valid_vec[(g == 0) ? 0 : g - 1]),
         .claim_in   (claim_chain[g]),
         .valid      (valid_vec[g]),
         .pending    (pending_vec[g]),
         .sel        (sel_vec[g]),
         .claim_out  (claim_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_op_ff <= '0;
         outer_mode_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COMPARE_OP: compare_op_ff <= csr_data[2:0];
            CSR_OUTER_MODE: outer_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_key_ff <= req_key_ext;
         cur_row_ff <= req_payload.right_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         dropped_ff   <= 1'b0;
         emitted_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  case (req_payload.operation)
                     OPER_LOAD: begin
                        if (store_full) begin
                           dropped_ff <= 1'b1;
                           state_ff   <= EMIT_STATUS;
                        end
                     end
                     OPER_PROBE:  state_ff <= PROBE_CMP;
                     OPER_FINISH: state_ff <= FIN_CMP;
                     default: ;
                  endcase
               end
            end
            PROBE_CMP: begin
               emitted_ff <= 1'b0;
               state_ff   <= EMIT_PROBE;
            end
            FIN_CMP: begin
               state_ff <= EMIT_FIN;
            end
            EMIT_PROBE: begin
               if (pending_any) begin
                  if (out_free) begin
                     rsp_ff.left_row      <= ROW_WIDTH'(sel_index);
                     rsp_ff.right_row_out <= cur_row_ff;
                     rsp_ff.left_null     <= 1'b0;
                     rsp_ff.right_null    <= 1'b0;
                     rsp_ff.last          <= !remaining_any;
                     rsp_ff.overflow      <= dropped_ff;
                     emitted_ff           <= 1'b1;
                     if (!remaining_any) begin
                        state_ff <= IDLE;
                     end
                  end
               end else if (outer_mode_ff[MODE_RIGHT_BIT] && !emitted_ff) begin
                  if (out_free) begin
                     rsp_ff.left_row      <= '0;
                     rsp_ff.right_row_out <= cur_row_ff;
                     rsp_ff.left_null     <= 1'b1;
                     rsp_ff.right_null    <= 1'b0;
                     rsp_ff.last          <= 1'b1;
                     rsp_ff.overflow      <= dropped_ff;
                     state_ff             <= IDLE;
                  end
               end else begin
                  state_ff <= IDLE;
               end
            end
            EMIT_FIN: begin
               if (pending_any) begin
                  if (out_free) begin
                     rsp_ff.left_row      <= ROW_WIDTH'(sel_index);
                     rsp_ff.right_row_out <= '0;
                     rsp_ff.left_null     <= 1'b0;
                     rsp_ff.right_null    <= 1'b1;
                     rsp_ff.last          <= !remaining_any;
                     rsp_ff.overflow      <= dropped_ff;
                     if (!remaining_any) begin
                        dropped_ff <= 1'b0;
                        state_ff   <= IDLE;
                     end
                  end
               end else begin
                  dropped_ff <= 1'b0;
                  state_ff   <= IDLE;
               end
            end
            EMIT_STATUS: begin
               if (out_free) begin
                  rsp_ff.left_row      <= '0;
                  rsp_ff.right_row_out <= '0;
                  rsp_ff.left_null     <= 1'b1;
                  rsp_ff.right_null    <= 1'b1;
                  rsp_ff.last          <= 1'b1;
                  rsp_ff.overflow      <= 1'b1;
                  state_ff             <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

[tb/theta_nested_loop_join_checker.sv]
// checker for the theta nested loop join: predicts row pairs and compares the result channel
`timescale 1ns / 1ps

module theta_nested_loop_join_checker
   import tnlj_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  req_type                    req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rsp_type                    rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         mismatch_count,
   output int                         rows_pending
);

   localparam int STORE_ROWS  = LEFT_ROWS_DEFAULT;
   localparam int PRINT_LIMIT = 50;

   logic signed [IN_KEY_WIDTH-1:0] left_keys [STORE_ROWS];
   logic [STORE_ROWS-1:0]          left_matched = '0;
   int                             left_count = 0;
   logic                           load_dropped = 1'b0;
   logic [2:0]                     compare_op = CMP_EQ;
   logic [1:0]                     outer_mode = '0;
   rsp_type                        expected_rows [$];
   int                             mismatch_total = 0;
   int                             pending_total = 0;

   assign mismatch_count = mismatch_total;
   assign rows_pending   = pending_total;

   task automatic report_mismatch(input string what);
      mismatch_total++;
      if (mismatch_total <= PRINT_LIMIT) begin
         $display("%0t: join row mismatch: %s", $time, what);
      end
   endtask

   function automatic logic key_hit(input logic signed [IN_KEY_WIDTH-1:0] lkey,
                                    input logic signed [IN_KEY_WIDTH-1:0] rkey);
      case (compare_op)
         CMP_EQ:  return lkey == rkey;
         CMP_NE:  return lkey != rkey;
         CMP_LT:  return lkey < rkey;
         CMP_LE:  return lkey <= rkey;
         CMP_GT:  return lkey > rkey;
         CMP_GE:  return lkey >= rkey;
         default: return 1'b0;
      endcase
   endfunction

   function automatic rsp_type join_row(input int lrow, input logic [RIGHT_ROW_WIDTH-1:0] rrow,
                                        input logic lnull, input logic rnull);
      rsp_type row;
      row.left_row      = lrow[ROW_WIDTH-1:0];
      row.right_row_out = rrow;
      row.left_null     = lnull;
      row.right_null    = rnull;
      row.last          = 1'b0;
      row.overflow      = load_dropped;
      return row;
   endfunction

   task automatic predict_join_rows(input req_type req);
      rsp_type rows [$];
      case (req.operation)
         OPER_LOAD: begin
            if (left_count < STORE_ROWS) begin
               left_keys[left_count]    = req.key;
               left_matched[left_count] = 1'b0;
               left_count++;
            end else begin
               load_dropped = 1'b1;
               rows = {rows, join_row(0, '0, 1'b1, 1'b1)};
            end
         end
         OPER_PROBE: begin
            for (int i = 0; i < left_count; i++) begin
               if (key_hit(left_keys[i], req.key)) begin
                  left_matched[i] = 1'b1;
                  rows = {rows, join_row(i, req.right_row, 1'b0, 1'b0)};
               end
            end
            if (rows.size() == 0 && outer_mode[MODE_RIGHT_BIT]) begin
               rows = {rows, join_row(0, req.right_row, 1'b1, 1'b0)};
            end
         end
         OPER_FINISH: begin
            if (outer_mode[MODE_LEFT_BIT]) begin
               for (int i = 0; i < left_count; i++) begin
                  if (!left_matched[i]) begin
                     rows = {rows, join_row(i, '0, 1'b0, 1'b1)};
                  end
               end
            end
            left_count   = 0;
            left_matched = '0;
            load_dropped = 1'b0;
         end
         default: ;
      endcase
      if (rows.size() > 0) begin
         rows[rows.size()-1].last = 1'b1;
      end
      expected_rows = {expected_rows, rows};
   endtask

   task automatic check_row(input rsp_type got);
      rsp_type want;
      if (expected_rows.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
      end else begin
         want = expected_rows.pop_front();
         if (got.left_row !== want.left_row)
            report_mismatch($sformatf("left_row %0d, want %0d", got.left_row, want.left_row));
         if (got.right_row_out !== want.right_row_out)
            report_mismatch($sformatf("right_row_out %0d, want %0d",
                                      got.right_row_out, want.right_row_out));
         if (got.left_null !== want.left_null)
            report_mismatch($sformatf("left_null %b, want %b", got.left_null, want.left_null));
         if (got.right_null !== want.right_null)
            report_mismatch($sformatf("right_null %b, want %b", got.right_null, want.right_null));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
         if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         left_count   = 0;
         left_matched = '0;
         load_dropped = 1'b0;
         compare_op   = CMP_EQ;
         outer_mode   = '0;
         expected_rows.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COMPARE_OP: compare_op = csr_data;
               CSR_OUTER_MODE: outer_mode = csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_row(rsp_payload);
         end
         if (req_valid && !req_stall) begin
            predict_join_rows(req_payload);
         end
      end
      pending_total = expected_rows.size();
   end

endmodule

[tb/theta_nested_loop_join_tb.sv]
// testbench top for the theta nested loop join: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module theta_nested_loop_join_tb;
   import tnlj_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int ITEM_TARGET   = 400;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 600000;

   localparam logic [1:0] OPER_UNUSED      = 2'd3;
   localparam logic [2:0] CMP_SPARE_LO     = 3'd6;
   localparam logic [2:0] CMP_SPARE_HI     = 3'd7;
   localparam logic [1:0] MODE_INNER       = 2'd0;
   localparam logic [1:0] MODE_LEFT_OUTER  = 2'd1;
   localparam logic [1:0] MODE_RIGHT_OUTER = 2'd2;
   localparam logic [1:0] MODE_FULL_OUTER  = 2'd3;

   localparam logic [2:0] CMP_CODES [8] = '{CMP_EQ, CMP_NE, CMP_LT, CMP_LE,
                                            CMP_GT, CMP_GE, CMP_SPARE_LO, CMP_SPARE_HI};
   localparam logic [1:0] MODE_CODES [4] = '{MODE_INNER, MODE_LEFT_OUTER,
                                             MODE_RIGHT_OUTER, MODE_FULL_OUTER};
   localparam int IDLE_PCTS [4]  = '{0, 53, 0, 32};
   localparam int STALL_PCTS [4] = '{0, 0, 53, 32};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic                       hold_req = 1'b0;
   int                         idle_pct = 0;
   int                         stall_pct = 0;
   int                         items_sent = 0;
   int                         cycle_count = 0;
   int                         mismatch_count;
   int                         rows_pending;

   always #CLOCK_HALF clock = ~clock;

   theta_nested_loop_join u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   theta_nested_loop_join_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .rows_pending     (rows_pending)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stall, with one long hold-off when asked
   initial begin
      int  hold_left;
      bit  hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (!hold_req) hold_seen = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic logic [IN_KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         4, 5:    return $urandom();
         default: return 32'($urandom_range(6)) - 32'd3;
      endcase
   endfunction

   function automatic logic [RIGHT_ROW_WIDTH-1:0] pick_row();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_req(input logic [1:0] oper, input logic [IN_KEY_WIDTH-1:0] key,
                           input logic [RIGHT_ROW_WIDTH-1:0] row);
      req_type req;
      req.operation = oper;
      req.key       = key;
      req.right_row = row;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      if (oper != OPER_UNUSED) items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] cmp, input logic [1:0] mode,
                            input int idle, input int stall);
      settle();
      idle_pct  = idle;
      stall_pct = stall;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_COMPARE_OP;
      csr_data         <= cmp;
      @(posedge clock);
      csr_index        <= CSR_OUTER_MODE;
      csr_data         <= {1'b0, mode};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_batch(input int loads, input int probes, input bit close);
      for (int i = 0; i < loads; i++) begin
         send_req(OPER_LOAD, pick_key(), pick_row());
      end
      for (int i = 0; i < probes; i++) begin
         if ($urandom_range(9) == 0) begin
            send_req(2'($urandom_range(3)), pick_key(), pick_row());
         end else begin
            send_req(OPER_PROBE, pick_key(), pick_row());
         end
      end
      if (close) send_req(OPER_FINISH, pick_key(), pick_row());
   endtask

   initial begin
      int phase;
      int phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty store, empty finish, unused operation
      send_req(OPER_PROBE, '0, 16'd7);
      send_req(OPER_FINISH, '0, '0);
      send_req(OPER_UNUSED, '1, '1);

      configure(CMP_EQ, MODE_RIGHT_OUTER, 0, 0);
      send_req(OPER_PROBE, 32'd9, 16'h1234);

      configure(CMP_EQ, MODE_FULL_OUTER, 0, 0);
      send_req(OPER_LOAD, 32'h8000_0000, '0);
      send_req(OPER_LOAD, 32'h7fff_ffff, '1);
      send_req(OPER_LOAD, '0, '0);
      send_req(OPER_LOAD, '1, '0);
      send_req(OPER_PROBE, '0, '1);
      send_req(OPER_PROBE, 32'd5, '0);
      for (int c = 1; c < 8; c++) begin
         configure(CMP_CODES[c], MODE_FULL_OUTER, 0, 0);
         send_req(OPER_PROBE, '0, 16'(c));
      end
      configure(CMP_GE, MODE_INNER, 0, 0);
      send_req(OPER_FINISH, '0, '0);

      // rows never probed still come out at finish
      configure(CMP_EQ, MODE_LEFT_OUTER, 0, 0);
      send_req(OPER_LOAD, 32'd1, '0);
      send_req(OPER_LOAD, 32'hffff_fffe, '0);
      send_req(OPER_LOAD, 32'h7fff_ffff, '0);
      send_req(OPER_FINISH, '0, '0);

      // full store with overflow while the result side holds off
      configure(CMP_NE, MODE_FULL_OUTER, 0, 0);
      hold_req <= 1'b1;
      run_batch(34, 6, 1'b1);
      hold_req <= 1'b0;

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         configure(CMP_CODES[phase % 8], MODE_CODES[phase % 4],
                   IDLE_PCTS[(phase / 2) % 4], STALL_PCTS[(phase / 2) % 4]);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            run_batch(($urandom_range(7) == 0) ? $urandom_range(20, 35) : $urandom_range(8),
                      $urandom_range(1, 8), $urandom_range(4) != 0);
         end
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[theta_nested_loop_join.f]
rtl/core/tnlj_pkg.sv
rtl/core/tnlj_cell.sv
rtl/core/theta_nested_loop_join.sv
tb/theta_nested_loop_join_checker.sv
tb/theta_nested_loop_join_tb.sv
